// File: design/euler_to_rigid_transform_assert.svh
// Assertion macros for the euler_to_rigid_transform block.
// Each use expands to one labeled concurrent assertion on clk_i, quiet during reset.
`ifndef EULER_TO_RIGID_TRANSFORM_ASSERT_SVH
`define EULER_TO_RIGID_TRANSFORM_ASSERT_SVH

// Plain property check, disabled while rst_ni is low.
`define ETR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ETR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/etr_pkg.sv
// ----------------------------------------------------------------------------
// etr_pkg
// Widths, constants and pipeline types shared by the Euler transform block.
// ----------------------------------------------------------------------------
`default_nettype none

package etr_pkg;

  localparam int unsigned MaxStages = 24;
  localparam int unsigned XW = 33;   // CORDIC x/y, Q1.30 plus headroom
  localparam int unsigned ZW = 26;   // CORDIC residual angle, 2^-16 degree
  localparam int unsigned SW = 22;   // sine/cosine, Q20
  localparam int unsigned PW = 44;   // product of two Q20 values
  localparam int unsigned LW = 21;   // low split of a pair product
  localparam int unsigned HW = PW - LW;
  localparam int unsigned VW = 64;   // matrix sum at 60 fractional bits

  localparam int HalfTurn    = 23040;
  localparam int FullTurn    = 46080;
  localparam int QuarterTurn = 11520;
  localparam int CordicGain  = 652032874;
  localparam int OneQ20      = 1048576;
  localparam int OneQ14      = 16384;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } lane_t;

  typedef struct packed {
    logic              vld;
    lane_t [2:0]       ln;   // 0 roll, 1 pitch, 2 yaw
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
  } cpipe_t;

  function automatic logic signed [ZW-1:0] atan_f(input int unsigned i);
    logic signed [ZW-1:0] r;
    unique case (i)
      0:  r = ZW'(2949120);
      1:  r = ZW'(1740967);
      2:  r = ZW'(919879);
      3:  r = ZW'(466945);
      4:  r = ZW'(234379);
      5:  r = ZW'(117304);
      6:  r = ZW'(58666);
      7:  r = ZW'(29335);
      8:  r = ZW'(14668);
      9:  r = ZW'(7334);
      10: r = ZW'(3667);
      11: r = ZW'(1833);
      12: r = ZW'(917);
      13: r = ZW'(458);
      14: r = ZW'(229);
      15: r = ZW'(115);
      16: r = ZW'(57);
      17: r = ZW'(29);
      18: r = ZW'(14);
      19: r = ZW'(7);
      20: r = ZW'(4);
      21: r = ZW'(2);
      22: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/etr_cordic_cell.sv
// ----------------------------------------------------------------------------
// etr_cordic_cell
// One rotation-mode CORDIC iteration for all three angle lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module etr_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            adv_i,
  input  wire etr_pkg::cpipe_t d_i,
  output etr_pkg::cpipe_t      q_o
);
  import etr_pkg::*;

  localparam logic signed [ZW-1:0] Atan = atan_f(STAGE);

  logic   vld_q;
  cpipe_t pay_d, pay_q;

  always_comb begin
    pay_d = d_i;
    for (int l = 0; l < 3; l++) begin
      if (!d_i.ln[l].z[ZW-1]) begin
        pay_d.ln[l].x = d_i.ln[l].x - (d_i.ln[l].y >>> STAGE);
        pay_d.ln[l].y = d_i.ln[l].y + (d_i.ln[l].x >>> STAGE);
        pay_d.ln[l].z = d_i.ln[l].z - Atan;
      end else begin
        pay_d.ln[l].x = d_i.ln[l].x + (d_i.ln[l].y >>> STAGE);
        pay_d.ln[l].y = d_i.ln[l].y - (d_i.ln[l].x >>> STAGE);
        pay_d.ln[l].z = d_i.ln[l].z + Atan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= d_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pay_q <= pay_d;
    end
  end

  always_comb begin
    q_o     = pay_q;
    q_o.vld = vld_q;
  end

endmodule

`default_nettype wire

// File: design/etr_matrix.sv
// ----------------------------------------------------------------------------
// etr_matrix
// Round CORDIC results to Q20 and build the nine Q2.14 rotation entries.
// ----------------------------------------------------------------------------
`default_nettype none

module etr_matrix (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire etr_pkg::cpipe_t    d_i,
  output logic                    vld_o,
  output logic signed [15:0]      m00_o,
  output logic signed [15:0]      m01_o,
  output logic signed [15:0]      m02_o,
  output logic signed [15:0]      m10_o,
  output logic signed [15:0]      m11_o,
  output logic signed [15:0]      m12_o,
  output logic signed [15:0]      m20_o,
  output logic signed [15:0]      m21_o,
  output logic signed [15:0]      m22_o,
  output logic signed [31:0]      x_o,
  output logic signed [31:0]      y_o,
  output logic signed [31:0]      z_o
);
  import etr_pkg::*;

  localparam logic signed [XW-1:0] OneX  = XW'(OneQ20);
  localparam logic signed [VW-1:0] HalfV = VW'(64'sd1 <<< 45);
  localparam logic signed [VW-1:0] OneV  = VW'(OneQ14);

  function automatic logic signed [SW-1:0] rnd20(input logic signed [XW-1:0] v,
                                                 input logic neg);
    logic signed [XW-1:0] r;
    logic signed [XW-1:0] c;
    r = (v + XW'(512)) >>> 10;
    if (r > OneX) c = OneX;
    else if (r < -OneX) c = -OneX;
    else c = r;
    if (neg) c = -c;
    return c[SW-1:0];
  endfunction

  function automatic logic signed [15:0] q14(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] r;
    r = (v + HalfV) >>> 46;
    if (r > OneV) r = OneV;
    else if (r < -OneV) r = -OneV;
    return r[15:0];
  endfunction

  logic [4:0] vld_q;
  logic signed [31:0] sx_q [5];
  logic signed [31:0] sy_q [5];
  logic signed [31:0] sz_q [5];

  // P0: sine and cosine, lanes roll/pitch/yaw
  logic signed [SW-1:0] s_q [3];
  logic signed [SW-1:0] c_q [3];

  // P1: pair products
  logic signed [PW-1:0] cpcy_q, cpsy_q, srcp_q, crcp_q, crsy_q, srsy_q, crcy_q, srcy_q;
  logic signed [PW-1:0] srsp_q, crsp_q;
  logic signed [SW-1:0] cy1_q, sy1_q, sp1_q;

  // P2: split triple products plus pair terms carried along
  logic signed [PW+1-1:0] hscy_q, hssy_q, hccy_q, hcsy_q;
  logic signed [PW-1:0]   lscy_q, lssy_q, lccy_q, lcsy_q;
  logic signed [PW-1:0]   cpcy2_q, cpsy2_q, srcp2_q, crcp2_q, crsy2_q, srsy2_q;
  logic signed [PW-1:0]   crcy2_q, srcy2_q;
  logic signed [SW-1:0]   sp2_q;

  // P3: sums at 60 fractional bits
  logic signed [VW-1:0] v_q [9];

  // P4: output register
  logic signed [15:0] m_q [9];

  function automatic logic signed [VW-1:0] tri3(input logic signed [PW:0] hi,
                                                input logic signed [PW-1:0] lo);
    return (VW'(hi) <<< LW) + VW'(lo);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[3:0], d_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sx_q[0] <= d_i.sx;
      sy_q[0] <= d_i.sy;
      sz_q[0] <= d_i.sz;
      for (int k = 1; k < 5; k++) begin
        sx_q[k] <= sx_q[k-1];
        sy_q[k] <= sy_q[k-1];
        sz_q[k] <= sz_q[k-1];
      end

      for (int l = 0; l < 3; l++) begin
        c_q[l] <= rnd20(d_i.ln[l].x, d_i.ln[l].neg);
        s_q[l] <= rnd20(d_i.ln[l].y, d_i.ln[l].neg);
      end

      cpcy_q <= c_q[1] * c_q[2];
      cpsy_q <= c_q[1] * s_q[2];
      srcp_q <= s_q[0] * c_q[1];
      crcp_q <= c_q[0] * c_q[1];
      crsy_q <= c_q[0] * s_q[2];
      srsy_q <= s_q[0] * s_q[2];
      crcy_q <= c_q[0] * c_q[2];
      srcy_q <= s_q[0] * c_q[2];
      srsp_q <= s_q[0] * s_q[1];
      crsp_q <= c_q[0] * s_q[1];
      cy1_q  <= c_q[2];
      sy1_q  <= s_q[2];
      sp1_q  <= s_q[1];

      hscy_q <= $signed(srsp_q[PW-1:LW]) * cy1_q;
      hssy_q <= $signed(srsp_q[PW-1:LW]) * sy1_q;
      hccy_q <= $signed(crsp_q[PW-1:LW]) * cy1_q;
      hcsy_q <= $signed(crsp_q[PW-1:LW]) * sy1_q;
      lscy_q <= $signed({1'b0, srsp_q[LW-1:0]}) * cy1_q;
      lssy_q <= $signed({1'b0, srsp_q[LW-1:0]}) * sy1_q;
      lccy_q <= $signed({1'b0, crsp_q[LW-1:0]}) * cy1_q;
      lcsy_q <= $signed({1'b0, crsp_q[LW-1:0]}) * sy1_q;
      cpcy2_q <= cpcy_q;
      cpsy2_q <= cpsy_q;
      srcp2_q <= srcp_q;
      crcp2_q <= crcp_q;
      crsy2_q <= crsy_q;
      srsy2_q <= srsy_q;
      crcy2_q <= crcy_q;
      srcy2_q <= srcy_q;
      sp2_q   <= sp1_q;

      v_q[0] <= VW'(cpcy2_q) <<< 20;
      v_q[1] <= -(VW'(cpsy2_q) <<< 20);
      v_q[2] <= VW'(sp2_q) <<< 40;
      v_q[3] <= (VW'(crsy2_q) <<< 20) + tri3(hscy_q, lscy_q);
      v_q[4] <= (VW'(crcy2_q) <<< 20) - tri3(hssy_q, lssy_q);
      v_q[5] <= -(VW'(srcp2_q) <<< 20);
      v_q[6] <= (VW'(srsy2_q) <<< 20) - tri3(hccy_q, lccy_q);
      v_q[7] <= (VW'(srcy2_q) <<< 20) + tri3(hcsy_q, lcsy_q);
      v_q[8] <= VW'(crcp2_q) <<< 20;

      for (int k = 0; k < 9; k++) begin
        m_q[k] <= q14(v_q[k]);
      end
    end
  end

  assign vld_o = vld_q[4];
  assign m00_o = m_q[0];
  assign m01_o = m_q[1];
  assign m02_o = m_q[2];
  assign m10_o = m_q[3];
  assign m11_o = m_q[4];
  assign m12_o = m_q[5];
  assign m20_o = m_q[6];
  assign m21_o = m_q[7];
  assign m22_o = m_q[8];
  assign x_o   = sx_q[4];
  assign y_o   = sy_q[4];
  assign z_o   = sz_q[4];

endmodule

`default_nettype wire

// File: design/euler_to_rigid_transform.sv
// ----------------------------------------------------------------------------
// euler_to_rigid_transform
// Roll/pitch/yaw plus translation to the top three rows of a rigid transform.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+-----------------------------------
//   in      | input     | in_valid_i/stall_o| roll/pitch/yaw angle, shift x/y/z
//   out     | output    | out_valid_o/stall_i| m00..m22, out_x/y/z
//
// One transfer per cycle in each direction when the output is not stalled.
// Data passes through the chain of CORDIC cells (CORDIC_STAGES, capped at 24),
// then through rounding, multiply and sum in the matrix unit.
// A stalled output freezes the whole pipeline and raises in_stall_o.
// Reset clears only the valid bits; payload registers keep whatever they hold.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_to_rigid_transform #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] roll_angle_i,
  input  wire logic signed [15:0] pitch_angle_i,
  input  wire logic signed [15:0] yaw_angle_i,
  input  wire logic signed [31:0] shift_x_i,
  input  wire logic signed [31:0] shift_y_i,
  input  wire logic signed [31:0] shift_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      m00_o,
  output logic signed [15:0]      m01_o,
  output logic signed [15:0]      m02_o,
  output logic signed [15:0]      m10_o,
  output logic signed [15:0]      m11_o,
  output logic signed [15:0]      m12_o,
  output logic signed [15:0]      m20_o,
  output logic signed [15:0]      m21_o,
  output logic signed [15:0]      m22_o,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [31:0]      out_z_o
);
  import etr_pkg::*;

  `include "euler_to_rigid_transform_assert.svh"

  localparam int unsigned NumStages =
      (CORDIC_STAGES > MaxStages) ? MaxStages : CORDIC_STAGES;

  // Whole pipeline moves together; it only holds while a result waits.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  cpipe_t chain [NumStages+1];

  logic signed [15:0] ang [3];
  assign ang[0] = roll_angle_i;
  assign ang[1] = pitch_angle_i;
  assign ang[2] = yaw_angle_i;

  // Angle reduction: wrap into [-180, 180), fold into [-90, 90], scale by 512.
  always_comb begin
    logic signed [16:0] a;
    chain[0].vld = in_valid_i;
    chain[0].sx  = shift_x_i;
    chain[0].sy  = shift_y_i;
    chain[0].sz  = shift_z_i;
    for (int l = 0; l < 3; l++) begin
      a = 17'(ang[l]);
      if (a >= 17'(HalfTurn)) a = a - 17'(FullTurn);
      else if (a < -17'(HalfTurn)) a = a + 17'(FullTurn);
      chain[0].ln[l].neg = 1'b0;
      if (a > 17'(QuarterTurn)) begin
        a = a - 17'(HalfTurn);
        chain[0].ln[l].neg = 1'b1;
      end else if (a < -17'(QuarterTurn)) begin
        a = a + 17'(HalfTurn);
        chain[0].ln[l].neg = 1'b1;
      end
      chain[0].ln[l].z = {a, 9'b0};
      chain[0].ln[l].x = XW'(CordicGain);
      chain[0].ln[l].y = '0;
    end
  end

  // Chain of CORDIC cells, one iteration each.
  for (genvar g = 0; g < NumStages; g++) begin : g_cell
    etr_cordic_cell #(.STAGE(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .d_i    (chain[g]),
      .q_o    (chain[g+1])
    );
  end

  etr_matrix u_matrix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .d_i    (chain[NumStages]),
    .vld_o  (out_valid_o),
    .m00_o  (m00_o),
    .m01_o  (m01_o),
    .m02_o  (m02_o),
    .m10_o  (m10_o),
    .m11_o  (m11_o),
    .m12_o  (m12_o),
    .m20_o  (m20_o),
    .m21_o  (m21_o),
    .m22_o  (m22_o),
    .x_o    (out_x_o),
    .y_o    (out_y_o),
    .z_o    (out_z_o)
  );

  `ETR_ASSERT(a_stall_tie, in_stall_o == (out_valid_o && out_stall_i), "stall not tied to held result")
  `ETR_ASSERT_NEXT(a_first_cell, !in_stall_o, chain[1].vld == $past(in_valid_i), "first cell lost transfer")
  `ETR_ASSERT(a_m_range, !out_valid_o || (m22_o <= 16'sd16384 && m22_o >= -16'sd16384 && m02_o <= 16'sd16384 && m02_o >= -16'sd16384), "entry out of range")

endmodule

`default_nettype wire
